// ===== src/assert_macros.svh =====
// Assertion macros shared by the Modbus RTU request framer RTL.
// Depends on nothing; included by each module that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check a property on every rising edge outside reset.
`define MRF_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Check a property on every rising edge, reset included.
`define MRF_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define MRF_ASSERT(lbl, clk, rst, prop)
`define MRF_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== src/mrf_pkg.sv =====
// Package of the Modbus RTU request framer: frame type, codes and CRC step.
// Depends on nothing; used by mrf_crc_pipe and modbus_rtu_request_framer.
`default_nettype none

package mrf_pkg;

  localparam int unsigned BODY_BYTES = 6;
  localparam int unsigned N_STAGES   = BODY_BYTES;

  localparam logic [1:0] KIND_READ_HOLDING = 2'd0;
  localparam logic [1:0] KIND_READ_INPUT   = 2'd1;
  localparam logic [1:0] KIND_WRITE_SINGLE = 2'd2;
  localparam logic [1:0] KIND_WRITE_SHORT  = 2'd3;

  localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
  localparam logic [7:0] FUNC_READ_INPUT   = 8'h04;
  localparam logic [7:0] FUNC_WRITE_SINGLE = 8'h06;
  localparam logic [7:0] FUNC_WRITE_SHORT  = 8'h10;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [2:0] POS_CRC_LO_LONG  = 3'd6;
  localparam logic [2:0] POS_CRC_LO_SHORT = 3'd4;
  localparam logic [2:0] POS_LAST_LONG    = 3'd7;
  localparam logic [2:0] POS_LAST_SHORT   = 3'd5;

  localparam logic [15:0] ADDR_OFFSET = 16'd1;

  typedef struct packed {
    logic [BODY_BYTES-1:0][7:0] body;
    logic                       short_frame;
  } frame_t;

  function automatic logic [7:0] func_code(input logic [1:0] kind);
    logic [7:0] code;
    unique case (kind)
      KIND_READ_HOLDING: code = FUNC_READ_HOLDING;
      KIND_READ_INPUT:   code = FUNC_READ_INPUT;
      KIND_WRITE_SINGLE: code = FUNC_WRITE_SINGLE;
      default:           code = FUNC_WRITE_SHORT;
    endcase
    return code;
  endfunction

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/modbus_rtu_request_framer.sv =====
// Top level of the Modbus RTU request framer: frame build, CRC pipe, byte output.
// Depends on mrf_pkg, mrf_crc_pipe and assert_macros.svh.
//
//  channel | signals                                              | role
//  in      | in_valid in_ready kind dev_address register_address  | one request per item
//          | value_or_count                                       |
//  out     | out_valid out_ready out_byte last_byte               | one frame byte per item
//
// A request passes six CRC stages, one body byte each (a short write folds only its four),
// then the byte output register, which sends one byte a cycle while out_ready is high: 8 bytes
// per request (6 for a short write) set the sustained rate; up to six requests wait in the pipe.
// Reset clears all valid bits. Stalls on out_ready back up stage by stage, losing nothing.
`default_nettype none

`include "assert_macros.svh"

module modbus_rtu_request_framer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  dev_address,
  input  logic [15:0] register_address,
  input  logic [15:0] value_or_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        last_byte
);

  mrf_pkg::frame_t new_frame;
  mrf_pkg::frame_t pipe_frame;
  logic [15:0]     pipe_crc;
  logic            pipe_valid;
  logic            pipe_ready;
  logic [15:0]     addr;

  // Build the frame body from the request.
  always_comb begin
    addr                  = register_address - mrf_pkg::ADDR_OFFSET;
    new_frame.short_frame = (kind == mrf_pkg::KIND_WRITE_SHORT);
    new_frame.body[0]     = dev_address;
    new_frame.body[1]     = mrf_pkg::func_code(kind);
    if (new_frame.short_frame) begin
      new_frame.body[2] = addr[7:0];
      new_frame.body[3] = value_or_count[7:0];
      new_frame.body[4] = 8'h00;
      new_frame.body[5] = 8'h00;
    end else begin
      new_frame.body[2] = addr[15:8];
      new_frame.body[3] = addr[7:0];
      new_frame.body[4] = value_or_count[15:8];
      new_frame.body[5] = value_or_count[7:0];
    end
  end

  mrf_crc_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_frame  (new_frame),
    .out_valid (pipe_valid),
    .out_ready (pipe_ready),
    .out_frame (pipe_frame),
    .out_crc   (pipe_crc)
  );

  logic            busy;
  logic [2:0]      pos;
  mrf_pkg::frame_t held;
  logic [15:0]     held_crc;
  logic [2:0]      crc_lo_pos;
  logic [2:0]      last_pos;

  assign crc_lo_pos = held.short_frame ? mrf_pkg::POS_CRC_LO_SHORT : mrf_pkg::POS_CRC_LO_LONG;
  assign last_pos   = held.short_frame ? mrf_pkg::POS_LAST_SHORT : mrf_pkg::POS_LAST_LONG;
  assign last_byte  = (pos == last_pos);
  assign out_valid  = busy;
  assign pipe_ready = ~busy | (out_ready & last_byte);

  always_comb begin
    if (pos == crc_lo_pos) begin
      out_byte = held_crc[7:0];
    end else if (pos == last_pos) begin
      out_byte = held_crc[15:8];
    end else begin
      out_byte = held.body[pos];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= '0;
    end else if (pipe_valid && pipe_ready) begin
      busy <= 1'b1;
      pos  <= '0;
    end else if (busy && out_ready) begin
      if (last_byte) begin
        busy <= 1'b0;
      end else begin
        pos <= pos + 3'd1;
      end
    end
    if (pipe_valid && pipe_ready) begin
      held     <= pipe_frame;
      held_crc <= pipe_crc;
    end
  end

  `MRF_ASSERT(a_short_pos, clk, rst, busy && held.short_frame |-> pos <= mrf_pkg::POS_LAST_SHORT)
  `MRF_ASSERT(a_advance, clk, rst, busy && out_ready && !last_byte |=> busy && pos == $past(pos) + 3'd1)
  `MRF_ASSERT(a_take_only_free, clk, rst, pipe_valid && pipe_ready |-> !busy || last_byte)

endmodule

`default_nettype wire

// ===== src/mrf_crc_pipe.sv =====
// CRC pipeline of the framer: one frame byte folded into the CRC per stage, except stages 4 and 5 of a short frame.
// Depends on mrf_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module mrf_crc_pipe (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  mrf_pkg::frame_t in_frame,
  output logic            out_valid,
  input  logic            out_ready,
  output mrf_pkg::frame_t out_frame,
  output logic [15:0]     out_crc
);

  localparam int unsigned N = mrf_pkg::N_STAGES;

  logic [N-1:0]    vld;
  logic [N:0]      rdy;
  mrf_pkg::frame_t frm [N];
  logic [15:0]     crc [N];

  assign rdy[N] = out_ready;

  for (genvar k = 0; k < N; k++) begin : g_stage
    assign rdy[k] = ~vld[k] | rdy[k+1];

    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (rdy[k]) begin
          vld[k] <= in_valid;
        end
        if (rdy[k] && in_valid) begin
          frm[k] <= in_frame;
          crc[k] <= mrf_pkg::crc_byte(mrf_pkg::CRC_INIT, in_frame.body[0]);
        end
      end
    end else begin : g_rest
      logic skip;
      assign skip = frm[k-1].short_frame && (k >= 4);

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
        if (rdy[k] && vld[k-1]) begin
          frm[k] <= frm[k-1];
          crc[k] <= skip ? crc[k-1] : mrf_pkg::crc_byte(crc[k-1], frm[k-1].body[k]);
        end
      end
    end

    `MRF_ASSERT(a_stall_hold, clk, rst, vld[k] && !rdy[k+1] |=> vld[k] && $stable(crc[k]))
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[N-1];
  assign out_frame = frm[N-1];
  assign out_crc   = crc[N-1];

  `MRF_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> vld == '0)
  `MRF_ASSERT(a_empty_ready, clk, rst, vld == '0 |-> in_ready)
  `MRF_ASSERT(a_short_tail, clk, rst, out_valid && out_frame.short_frame && $past(out_valid) && !$past(out_ready) |-> $stable(out_crc))

endmodule

`default_nettype wire

// ===== verif/modbus_rtu_request_framer_check.sv =====
// Checker of the Modbus RTU request framer: watches both channels, builds each request's
// frame with its own CRC-16, and compares every output byte and last marker in order.
// Depends on mrf_pkg for the kind and function codes and the CRC constants.
module modbus_rtu_request_framer_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  dev_address,
  input  logic [15:0] register_address,
  input  logic [15:0] value_or_count,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte,
  input  logic        last_byte,
  output int unsigned errors,
  output int unsigned pending_bytes
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  frame_byte_t expected_bytes[$];

  initial begin
    errors = 0;
    pending_bytes = 0;
  end

  function automatic logic [15:0] crc16_modbus(input logic [15:0] acc, input logic [7:0] data);
    logic feedback;
    for (int b = 0; b < 8; b++) begin
      feedback = acc[0] ^ data[b];
      acc = acc >> 1;
      if (feedback) begin
        acc = acc ^ mrf_pkg::CRC_POLY;
      end
    end
    return acc;
  endfunction

  // Build the whole frame of one request and queue its bytes.
  task automatic predict_frame(input logic [1:0] k, input logic [7:0] dev,
                               input logic [15:0] reg_addr, input logic [15:0] val);
    logic [7:0]  fb[8];
    logic [15:0] wire_addr;
    logic [15:0] crc;
    int          body_len;
    frame_byte_t item;
    wire_addr = reg_addr - mrf_pkg::ADDR_OFFSET;
    fb[0] = dev;
    case (k)
      mrf_pkg::KIND_READ_HOLDING: fb[1] = mrf_pkg::FUNC_READ_HOLDING;
      mrf_pkg::KIND_READ_INPUT:   fb[1] = mrf_pkg::FUNC_READ_INPUT;
      mrf_pkg::KIND_WRITE_SINGLE: fb[1] = mrf_pkg::FUNC_WRITE_SINGLE;
      default:                    fb[1] = mrf_pkg::FUNC_WRITE_SHORT;
    endcase
    if (k == mrf_pkg::KIND_WRITE_SHORT) begin
      fb[2] = wire_addr[7:0];
      fb[3] = val[7:0];
      body_len = 4;
    end else begin
      fb[2] = wire_addr[15:8];
      fb[3] = wire_addr[7:0];
      fb[4] = val[15:8];
      fb[5] = val[7:0];
      body_len = 6;
    end
    crc = mrf_pkg::CRC_INIT;
    for (int i = 0; i < body_len; i++) begin
      crc = crc16_modbus(crc, fb[i]);
    end
    fb[body_len]     = crc[7:0];
    fb[body_len + 1] = crc[15:8];
    for (int i = 0; i < body_len + 2; i++) begin
      item.data = fb[i];
      item.last = (i == body_len + 1);
      expected_bytes.insert(expected_bytes.size(), item);
    end
  endtask

  task automatic report(input string msg);
    $display("%0t: frame mismatch: %s", $realtime, msg);
    errors = errors + 1;
  endtask

  always @(posedge clk) begin
    frame_byte_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        predict_frame(kind, dev_address, register_address, value_or_count);
      end
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          report($sformatf("unexpected byte %02h last %0b", out_byte, last_byte));
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want.data) begin
            report($sformatf("byte %02h, expected %02h", out_byte, want.data));
          end
          if (last_byte !== want.last) begin
            report($sformatf("last %0b, expected %0b", last_byte, want.last));
          end
        end
      end
      pending_bytes <= expected_bytes.size();
    end
  end

endmodule

// ===== verif/modbus_rtu_request_framer_test.sv =====
// Testbench top of the Modbus RTU request framer: clock, reset, request stimulus and
// receiver stalls; depends on modbus_rtu_request_framer and modbus_rtu_request_framer_check.
module modbus_rtu_request_framer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS = 360;
  localparam int unsigned QUIET_FROM   = 300;
  localparam int unsigned HOLD_AT      = 120;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  kind = mrf_pkg::KIND_READ_HOLDING;
  logic [7:0]  dev_address = 8'h00;
  logic [15:0] register_address = 16'h0000;
  logic [15:0] value_or_count = 16'h0000;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        last_byte;

  int unsigned errors;
  int unsigned pending_bytes;
  int unsigned accepted = 0;
  int unsigned cycles = 0;
  logic        quiet = 1'b0;
  logic        hold_on = 1'b0;
  logic        hold_done = 1'b0;

  modbus_rtu_request_framer uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .dev_address(dev_address),
    .register_address(register_address), .value_or_count(value_or_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_byte(out_byte), .last_byte(last_byte)
  );

  modbus_rtu_request_framer_check frame_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .dev_address(dev_address),
    .register_address(register_address), .value_or_count(value_or_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_byte(out_byte), .last_byte(last_byte),
    .errors(errors), .pending_bytes(pending_bytes)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (in_valid && in_ready) begin
      accepted <= accepted + 1;
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_request(input logic [1:0] k, input logic [7:0] dev,
                              input logic [15:0] reg_addr, input logic [15:0] val);
    in_valid <= 1'b1;
    kind <= k;
    dev_address <= dev;
    register_address <= reg_addr;
    value_or_count <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic idle_sender;
    if (!quiet && !hold_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Receiver: random stall bursts, one long hold-off to fill the block, then none at the end.
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!hold_done && accepted >= HOLD_AT) begin
        out_ready <= 1'b0;
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
        hold_on <= 1'b0;
        hold_done <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  initial begin
    logic [1:0]  k;
    logic [15:0] reg_addr;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(mrf_pkg::KIND_READ_HOLDING, 8'h01, 16'h0001, 16'h000A);
    send_request(mrf_pkg::KIND_READ_INPUT,   8'h11, 16'h006B, 16'h0003);
    send_request(mrf_pkg::KIND_WRITE_SINGLE, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_request(mrf_pkg::KIND_WRITE_SHORT,  8'h00, 16'h0000, 16'h0000);
    send_request(mrf_pkg::KIND_READ_HOLDING, 8'h00, 16'h0000, 16'hFFFF);
    send_request(mrf_pkg::KIND_READ_INPUT,   8'hFF, 16'h0000, 16'h0000);
    send_request(mrf_pkg::KIND_WRITE_SINGLE, 8'h00, 16'h0000, 16'h8000);
    send_request(mrf_pkg::KIND_WRITE_SHORT,  8'hFF, 16'hFFFF, 16'hFFFF);
    send_request(mrf_pkg::KIND_WRITE_SHORT,  8'h5A, 16'hAB01, 16'hCD00);
    send_request(mrf_pkg::KIND_WRITE_SHORT,  8'hA5, 16'h0001, 16'h00FF);
    send_request(mrf_pkg::KIND_READ_HOLDING, 8'hAA, 16'hAAAA, 16'h5555);
    send_request(mrf_pkg::KIND_READ_INPUT,   8'h55, 16'h5555, 16'hAAAA);
    send_request(mrf_pkg::KIND_WRITE_SINGLE, 8'h80, 16'h8000, 16'h0001);
    send_request(mrf_pkg::KIND_READ_HOLDING, 8'h7F, 16'h0100, 16'hFF00);
    send_request(mrf_pkg::KIND_WRITE_SHORT,  8'h01, 16'h0100, 16'h1234);
    send_request(mrf_pkg::KIND_READ_INPUT,   8'h01, 16'h0001, 16'h007D);
    idle_sender();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == QUIET_FROM) begin
        quiet <= 1'b1;
      end
      k = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0:       reg_addr = 16'h0000;
        1:       reg_addr = 16'h0001;
        default: reg_addr = 16'($urandom_range(0, 16'hFFFF));
      endcase
      send_request(k, 8'($urandom_range(0, 8'hFF)), reg_addr,
                   16'($urandom_range(0, 16'hFFFF)));
      idle_sender();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending_bytes != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
